// ===== hw/rtl/stpg_pkg.sv =====
// ----------------------------------------------------------------------------
// stpg_pkg
// Shared types and codes of the two-axis step pulse generator.
// ----------------------------------------------------------------------------
package stpg_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_ABORT = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	localparam logic CFG_CRUISE   = 1'b0;
	localparam logic CFG_RAMP_LEN = 1'b1;

	localparam int CFG_DATA_BITS    = 24;
	localparam int FIELD_STEP_BITS  = 24;
	localparam int FIELD_INDEX_BITS = 10;
	localparam int FIELD_VALUE_BITS = 24;
	localparam int RAMP_LEN_BITS    = 11;

	localparam logic [23:0] CRUISE_RESET   = 24'd100;
	localparam logic [10:0] RAMP_LEN_RESET = 11'd1024;

	// Enables of the ramp table ports.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

// ===== hw/rtl/stpg_ramp_mem.sv =====
// ----------------------------------------------------------------------------
// stpg_ramp_mem
// Ramp interval table: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module stpg_ramp_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  stpg_pkg::mem_ctl_t       ctl,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	import stpg_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/two_axis_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// two_axis_step_pulse_generator
// Two-axis stepper pulse generator with a trapezoid speed ramp and a
// Bresenham line interpolator.
//
//   port group   dir   fields (low bit first)
//   s_axis_*     in    tuser: op; tdata: steps_x, steps_y, table_index,
//                      table_value
//   m_axis_*     out   tdata: step_x, step_y, dir_x, dir_y, motors_enabled,
//                      busy_res, accepted
//   cfg_*        in    0 cruise_ticks, 1 ramp_length
//
// A new word is taken in every cycle while the result register is empty or
// being drained.
// A step that loads its next interval from the ramp table reads the table in
// that cycle; the registered read data is used by the following tick.
// Reset clears all control state; the ramp table holds no reset value.
// ----------------------------------------------------------------------------
module two_axis_step_pulse_generator #(
	parameter int RAMP_DEPTH      = 1024,
	parameter int STEP_COUNT_BITS = 24,
	parameter int INTERVAL_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // steps_x, steps_y, table_index, table_value
	input  logic [1:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // step_x, step_y, dir_x, dir_y, motors_enabled,
	                                   // busy_res, accepted
);
	import stpg_pkg::*;

	localparam int CW = STEP_COUNT_BITS;
	localparam int IB = INTERVAL_BITS;
	localparam int EW = CW + 2;
	localparam int AW = $clog2(RAMP_DEPTH);
	localparam int MW = (CW > AW) ? CW : AW;
	localparam int IW = (AW > FIELD_INDEX_BITS) ? AW : FIELD_INDEX_BITS;
	localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;
	localparam logic [32:0] DEPTH33 = 33'(RAMP_DEPTH);

	logic [23:0] cruise_q;
	logic [10:0] ramp_len_q;

	logic                 moving_q, moving_n;
	logic signed [EW-1:0] err_q, err_n;
	logic [CW-1:0]        step_cnt_q, step_cnt_n;
	logic [IB-1:0]        ticks_q, ticks_n;
	logic                 tbl_pend_q, tbl_pend_n;
	logic [CW-1:0]        minor_q, minor_n;
	logic [CW-1:0]        major_q, major_n;
	logic [CW-1:0]        accel_end_q, accel_end_n;
	logic [CW-1:0]        decel_q, decel_n;
	logic                 x_major_q, x_major_n;
	logic                 sx_q, sx_n, sy_q, sy_n, dx_q, dx_n, dy_q, dy_n, en_q, en_n;
	logic                 acc_n;
	logic [7:0]           out_q;
	logic                 out_valid_q;

	op_t                  op;
	logic [23:0]          f_sx, f_sy, f_val;
	logic [9:0]           f_idx;
	logic                 in_acc;

	mem_ctl_t             mem_ctl;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [IB-1:0]        rd_data;

	logic [23:0]          mag_x, mag_y;
	logic [32:0]          ax33, ay33, maj33, min33, ramp33;
	logic [IB-1:0]        ticks_eff;
	logic signed [EW-1:0] err_add;
	logic [CW-1:0]        done_cnt, idx_c;
	logic [IW-1:0]        idx_ext;

	assign op    = op_t'(s_axis_tuser);
	assign f_sx  = s_axis_tdata[23:0];
	assign f_sy  = s_axis_tdata[47:24];
	assign f_idx = s_axis_tdata[57:48];
	assign f_val = s_axis_tdata[81:58];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruise_q   <= CRUISE_RESET;
			ramp_len_q <= RAMP_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CRUISE:   cruise_q   <= cfg_data;
				CFG_RAMP_LEN: ramp_len_q <= cfg_data[RAMP_LEN_BITS-1:0];
			endcase
		end
	end

	assign mag_x  = f_sx[23] ? (~f_sx + 24'd1) : f_sx;
	assign mag_y  = f_sy[23] ? (~f_sy + 24'd1) : f_sy;
	assign ax33   = (33'(mag_x) > CNT_MAX) ? CNT_MAX : 33'(mag_x);
	assign ay33   = (33'(mag_y) > CNT_MAX) ? CNT_MAX : 33'(mag_y);
	assign maj33  = (ax33 > ay33) ? ax33 : ay33;
	assign min33  = (ax33 > ay33) ? ay33 : ax33;
	assign ramp33 = (33'(ramp_len_q) > DEPTH33) ? DEPTH33 : 33'(ramp_len_q);

	assign ticks_eff = tbl_pend_q ? (rd_data - IB'(1)) : ticks_q;
	assign err_add   = err_q + $signed(EW'(minor_q));
	assign done_cnt  = step_cnt_q - decel_q;
	assign idx_ext   = IW'(f_idx);
	assign wr_addr   = idx_ext[AW-1:0];

	always_comb begin
		logic [MW-1:0] idx_w;
		moving_n    = moving_q;
		err_n       = err_q;
		step_cnt_n  = step_cnt_q;
		ticks_n     = ticks_q;
		tbl_pend_n  = tbl_pend_q;
		minor_n     = minor_q;
		major_n     = major_q;
		accel_end_n = accel_end_q;
		decel_n     = decel_q;
		x_major_n   = x_major_q;
		sx_n        = sx_q;
		sy_n        = sy_q;
		dx_n        = dx_q;
		dy_n        = dy_q;
		en_n        = en_q;
		acc_n       = 1'b0;
		mem_ctl     = '0;

		if (step_cnt_q < accel_end_q) begin
			idx_c = step_cnt_q;
		end else if (done_cnt >= accel_end_q) begin
			idx_c = '0;
		end else begin
			idx_c = accel_end_q - done_cnt - CW'(1);
		end
		idx_w   = MW'(idx_c);
		rd_addr = idx_w[AW-1:0];

		if (in_acc) begin
			case (op)
				OP_TICK: begin
					if (moving_q) begin
						sx_n = 1'b0;
						sy_n = 1'b0;
						if (ticks_eff != '0) begin
							ticks_n    = ticks_eff - IB'(1);
							tbl_pend_n = 1'b0;
						end else if (step_cnt_q >= major_q) begin
							en_n     = 1'b0;
							moving_n = 1'b0;
						end else begin
							if (x_major_q) sx_n = 1'b1;
							else           sy_n = 1'b1;
							err_n = err_add;
							if (!err_add[EW-1]) begin
								if (x_major_q) sy_n = 1'b1;
								else           sx_n = 1'b1;
								err_n = err_add - $signed(EW'(major_q));
							end
							if (step_cnt_q >= accel_end_q && step_cnt_q < decel_q) begin
								ticks_n    = IB'(cruise_q) - IB'(1);
								tbl_pend_n = 1'b0;
							end else begin
								mem_ctl.rd_en = 1'b1;
								tbl_pend_n    = 1'b1;
							end
							step_cnt_n = step_cnt_q + CW'(1);
						end
					end
				end
				OP_START: begin
					if (!moving_q) begin
						acc_n     = 1'b1;
						x_major_n = ax33 > ay33;
						major_n   = CW'(maj33);
						minor_n   = CW'(min33);
						if (maj33 >= (ramp33 << 1)) begin
							accel_end_n = CW'(ramp33);
							decel_n     = CW'(maj33 - ramp33);
						end else begin
							accel_end_n = CW'(maj33 >> 1);
							decel_n     = CW'(maj33 >> 1);
						end
						err_n      = -$signed(EW'(maj33 >> 1));
						ticks_n    = '0;
						tbl_pend_n = 1'b0;
						step_cnt_n = '0;
						en_n       = 1'b1;
						dx_n       = !f_sx[23] && (f_sx != '0);
						dy_n       = !f_sy[23] && (f_sy != '0);
						moving_n   = 1'b1;
					end
				end
				OP_ABORT: begin
					sx_n     = 1'b0;
					sy_n     = 1'b0;
					en_n     = 1'b0;
					moving_n = 1'b0;
				end
				default: begin
					if (!moving_q && (33'(f_idx) < DEPTH33)) begin
						mem_ctl.wr_en = 1'b1;
						acc_n         = 1'b1;
					end
				end
			endcase
		end
	end

	stpg_ramp_mem #(
		.DEPTH (RAMP_DEPTH),
		.WIDTH (IB)
	) u_ramp_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (IB'(f_val)),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q    <= 1'b0;
			err_q       <= '0;
			step_cnt_q  <= '0;
			ticks_q     <= '0;
			tbl_pend_q  <= 1'b0;
			minor_q     <= '0;
			major_q     <= '0;
			accel_end_q <= '0;
			decel_q     <= '0;
			x_major_q   <= 1'b0;
			sx_q        <= 1'b0;
			sy_q        <= 1'b0;
			dx_q        <= 1'b0;
			dy_q        <= 1'b0;
			en_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (in_acc) begin
				moving_q    <= moving_n;
				err_q       <= err_n;
				step_cnt_q  <= step_cnt_n;
				ticks_q     <= ticks_n;
				tbl_pend_q  <= tbl_pend_n;
				minor_q     <= minor_n;
				major_q     <= major_n;
				accel_end_q <= accel_end_n;
				decel_q     <= decel_n;
				x_major_q   <= x_major_n;
				sx_q        <= sx_n;
				sy_q        <= sy_n;
				dx_q        <= dx_n;
				dy_q        <= dy_n;
				en_q        <= en_n;
				out_q       <= {1'b0, acc_n, moving_n, en_n, dy_n, dx_n, sy_n, sx_n};
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	a_pulse_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1]) |-> m_axis_tdata[4])
		else $error("step pulse without motor enable");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> step_cnt_q <= major_q)
		else $error("step count passed the major step count");

	a_error_negative: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q && (major_q > CW'(1)) |-> err_q[EW-1])
		else $error("line error left its range");

	a_busy_start_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (op == OP_START) && moving_q |=> !m_axis_tdata[6])
		else $error("start taken during a move");

endmodule

// ===== tb/tb_two_axis_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// tb_two_axis_step_pulse_generator
// Self-checking bench for the two-axis step pulse generator. A generator
// queues table loads, starts, ticks and aborts under several register
// settings, predicts the pin word of every item, and a monitor compares each
// output word field by field; both sides idle at random except one phase.
// ----------------------------------------------------------------------------
module tb_two_axis_step_pulse_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import stpg_pkg::*;

	localparam int DEPTH = 1024;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		op_t         op;
		logic [23:0] sx;
		logic [23:0] sy;
		logic [9:0]  idx;
		logic [23:0] val;
	} motion_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_CRUISE;
	logic [23:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	motion_word_t pending_words [$];
	logic [7:0]   pin_words_due [$];
	motion_word_t drive_word;
	logic [7:0]   want_word;
	int           errors = 0;
	int           sent = 0;
	int           quiet_cycles = 0;
	bit           steady = 1'b0;
	string        field_name [8] = '{"step_x", "step_y", "dir_x", "dir_y",
		"motors_enabled", "busy_res", "accepted", "pad"};

	// Shadow state of the motion planner.
	logic [23:0] ramp_tbl [DEPTH];
	bit          tbl_written [DEPTH];
	logic [23:0] cruise_iv = CRUISE_RESET;
	logic [10:0] ramp_len = RAMP_LEN_RESET;
	bit          moving_q = 1'b0;
	longint      bres_err = 0;
	int          steps_done = 0;
	logic [23:0] wait_ticks = '0;
	int          minor_cnt = 0;
	int          major_cnt = 0;
	int          accel_stop = 0;
	int          decel_from = 0;
	bit          x_major = 1'b0;
	logic [4:0]  pins = '0;	// step_x, step_y, dir_x, dir_y, enable

	two_axis_step_pulse_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [23:0] abs24(logic [23:0] v);
		return v[23] ? (~v + 24'd1) : v;
	endfunction

	// Ramp table entry that the next step loads, if the step uses the table.
	function automatic bit table_slot(output int slot);
		int done;
		slot = 0;
		if (steps_done < accel_stop) begin
			slot = steps_done;
			return 1'b1;
		end
		if (steps_done < decel_from)
			return 1'b0;
		done = steps_done - decel_from;
		slot = (done >= accel_stop) ? 0 : accel_stop - done - 1;
		return 1'b1;
	endfunction

	function automatic logic [7:0] advance_motion(motion_word_t w);
		logic [23:0] ax;
		logic [23:0] ay;
		logic [23:0] iv;
		int          ramp;
		int          slot;
		bit          acc;
		acc = 1'b0;
		case (w.op)
			OP_TICK: begin
				if (moving_q) begin
					pins[1:0] = 2'b00;
					if (wait_ticks != 0) begin
						wait_ticks = wait_ticks - 24'd1;
					end else if (steps_done >= major_cnt) begin
						pins[4] = 1'b0;
						moving_q = 1'b0;
					end else begin
						pins[x_major ? 0 : 1] = 1'b1;
						bres_err += minor_cnt;
						if (bres_err >= 0) begin
							pins[x_major ? 1 : 0] = 1'b1;
							bres_err -= major_cnt;
						end
						if (table_slot(slot))
							iv = ramp_tbl[slot];
						else
							iv = cruise_iv;
						wait_ticks = iv - 24'd1;
						steps_done++;
					end
				end
			end
			OP_START: begin
				if (!moving_q) begin
					ax = abs24(w.sx);
					ay = abs24(w.sy);
					ramp = (ramp_len > 11'd1024) ? 1024 : int'(ramp_len);
					x_major = ax > ay;
					major_cnt = x_major ? int'(ax) : int'(ay);
					minor_cnt = x_major ? int'(ay) : int'(ax);
					if (major_cnt >= 2 * ramp) begin
						accel_stop = ramp;
						decel_from = major_cnt - ramp;
					end else begin
						accel_stop = major_cnt / 2;
						decel_from = accel_stop;
					end
					bres_err = -longint'(major_cnt / 2);
					wait_ticks = '0;
					steps_done = 0;
					pins[4] = 1'b1;
					pins[2] = (w.sx != 0) && !w.sx[23];
					pins[3] = (w.sy != 0) && !w.sy[23];
					moving_q = 1'b1;
					acc = 1'b1;
				end
			end
			OP_ABORT: begin
				pins[0] = 1'b0;
				pins[1] = 1'b0;
				pins[4] = 1'b0;
				moving_q = 1'b0;
			end
			default: begin
				if (!moving_q) begin
					ramp_tbl[w.idx] = w.val;
					tbl_written[w.idx] = 1'b1;
					acc = 1'b1;
				end
			end
		endcase
		return {1'b0, acc, moving_q, pins};
	endfunction

	function automatic motion_word_t rand_word(op_t op);
		motion_word_t w;
		w.op = op;
		w.sx = 24'($urandom);
		w.sy = 24'($urandom);
		w.idx = 10'($urandom);
		w.val = 24'($urandom);
		return w;
	endfunction

	task automatic send(motion_word_t w);
		pin_words_due.push_back(advance_motion(w));
		pending_words.push_back(w);
		sent++;
	endtask

	task automatic send_start(logic [23:0] x, logic [23:0] y);
		motion_word_t w;
		w = rand_word(OP_START);
		w.sx = x;
		w.sy = y;
		send(w);
	endtask

	task automatic send_load(logic [9:0] idx, logic [23:0] val);
		motion_word_t w;
		w = rand_word(OP_LOAD);
		w.idx = idx;
		w.val = val;
		send(w);
	endtask

	// A tick that would make the block read a ramp entry never written is
	// turned into an abort.
	task automatic send_tick();
		motion_word_t w;
		int slot;
		w = rand_word(OP_TICK);
		if (moving_q && wait_ticks == 0 && steps_done < major_cnt && table_slot(slot)
				&& !tbl_written[slot])
			w.op = OP_ABORT;
		send(w);
	endtask

	task automatic finish_move(int max_ticks);
		int k;
		k = 0;
		while (moving_q && k < max_ticks) begin
			send_tick();
			k++;
		end
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || pin_words_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [23:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CRUISE)
			cruise_iv = v;
		else
			ramp_len = v[10:0];
	endtask

	task automatic random_move(int big_pct);
		int          n;
		int          r;
		logic [9:0]  idx;
		logic [23:0] val;
		logic [23:0] x;
		logic [23:0] y;
		n = $urandom_range(0, 3);
		repeat (n) begin
			idx = ($urandom_range(0, 99) < 80) ? 10'($urandom_range(0, 63))
				: 10'($urandom_range(0, 1023));
			val = ($urandom_range(0, 99) < 88) ? 24'($urandom_range(1, 6)) : 24'($urandom);
			send_load(idx, val);
		end
		if ($urandom_range(0, 99) < 3)
			send(rand_word(OP_ABORT));
		if ($urandom_range(0, 99) < 3)
			send_tick();
		if ($urandom_range(0, 99) < big_pct) begin
			x = 24'($urandom);
			y = 24'($urandom);
		end else begin
			x = 24'($urandom_range(0, 60));
			y = 24'($urandom_range(0, 60));
			if ($urandom_range(0, 1))
				x = -x;
			if ($urandom_range(0, 1))
				y = -y;
		end
		send_start(x, y);
		n = $urandom_range(10, 250);
		for (int k = 0; k < n && moving_q; k++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				send(rand_word(OP_START));
			else if (r < 4)
				send(rand_word(OP_LOAD));
			else
				send_tick();
		end
		if (moving_q && $urandom_range(0, 99) < 60)
			send(rand_word(OP_ABORT));
	endtask

	task automatic run_phase(logic [23:0] cruise, logic [10:0] ramp, int budget, int big_pct);
		int goal;
		int mid;
		bit paused;
		drain();
		repeat (4) @(posedge clk);
		write_reg(CFG_CRUISE, cruise);
		write_reg(CFG_RAMP_LEN, {13'd0, ramp});
		goal = sent + budget;
		mid = sent + budget / 2;
		paused = 1'b0;
		while (sent < goal) begin
			random_move(big_pct);
			if (!paused && sent >= mid) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= OP_TICK;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
					drive_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, drive_word.val, drive_word.idx, drive_word.sy, drive_word.sx};
					s_tuser <= drive_word.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 27);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pin_words_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: output word %b with nothing expected", $time, m_tdata);
			end else begin
				want_word = pin_words_due.pop_front();
				for (int f = 0; f < 8; f++) begin
					if (m_tdata[f] !== want_word[f]) begin
						errors++;
						if (errors <= 10)
							$display("%0t: %s expected %b got %b", $time, field_name[f],
								want_word[f], m_tdata[f]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_two_axis_step_pulse_generator failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(rand_word(OP_TICK));
		send(rand_word(OP_ABORT));
		send_load(10'd0, 24'd1);
		send_load(10'd1, 24'd2);
		send_load(10'd2, 24'd1);
		send_load(10'd3, 24'd3);
		send_load(10'd4, 24'd1);
		send_load(10'd5, 24'd2);
		send_load(10'd1023, 24'hFFFFFF);
		send_start(24'd0, 24'd0);
		send_tick();
		send_start(24'd3, -24'sd3);
		finish_move(20);
		send_start(-24'sd5, 24'd2);
		send_start(24'd1, 24'd1);
		send_load(10'd6, 24'd1);
		finish_move(30);
		send_start(24'h800000, 24'h7FFFFF);
		finish_move(6);
		send(rand_word(OP_ABORT));
		// A zero interval wraps to the longest countdown.
		send_load(10'd0, 24'd0);
		send_start(24'd4, 24'd1);
		finish_move(4);
		send(rand_word(OP_ABORT));
		send_load(10'd0, 24'd1);

		sent = 0;
		run_phase(CRUISE_RESET, RAMP_LEN_RESET, 250, 10);
		run_phase(24'd1, 11'd2047, 250, 10);
		steady = 1'b1;
		run_phase(24'd3, 11'd6, 300, 5);
		steady = 1'b0;
		run_phase(24'd0, 11'd0, 100, 10);
		run_phase(24'hFFFFFF, 11'd1, 150, 10);
		run_phase(24'd2, 11'd1024, 400, 5);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_two_axis_step_pulse_generator passed");
		else
			$display("tb_two_axis_step_pulse_generator failed");
		$finish;
	end

endmodule
